/* rtl/core/lsbx_pkg.sv */
// lsbx_pkg: shared types and constants for the lsb stego byte extractor
// no dependencies
`timescale 1ns / 1ps

package lsbx_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP_PIXELS = 1'b0,
    CFG_DECRYPT     = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] TERMINATOR = 8'h7C;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // raw byte from the front end, tagged when it is the terminator
  typedef struct packed {
    logic [7:0] raw;
    logic       is_end;
  } lsbx_item_t;

endpackage

/* rtl/core/lsb_stego_byte_extractor_unit.sv */
// lsb_stego_byte_extractor_unit: top level of the lsb stego byte extractor
// depends on lsbx_pkg, lsbx_front, lsbx_queue, lsbx_back
`timescale 1ns / 1ps

// Takes one RGB pixel per clock and rebuilds hidden bytes from the two low
// bits of red, green and blue, most significant pair first, after skipping
// skip_pixels leading pixels of each frame. A '|' byte gives one result with
// end_found set and char_value 0, and pixels are then ignored until the next
// frame_start. With decrypt_enable set each byte is shifted down by one ('a'
// to 'z', 'A' to 'Z', space unchanged). The block takes a pixel every cycle
// while in_ready is high; a result passes through the queue and the output
// register, and a QUEUE_DEPTH entry queue between the packing front end and
// the output stage absorbs output stalls before in_ready drops.

module lsb_stego_byte_extractor_unit import lsbx_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            char_value,
  output logic                  end_found,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] skip_pixels;
  logic        decrypt_enable;
  logic        queue_full;
  logic        push;
  lsbx_item_t  push_item;
  logic        pop;
  logic        head_valid;
  lsbx_item_t  head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_pixels <= '0;
      decrypt_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SKIP_PIXELS: skip_pixels <= cfg_data[15:0];
        CFG_DECRYPT:     decrypt_enable <= cfg_data[0];
      endcase
    end
  end

  lsbx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .frame_start (frame_start),
    .skip_pixels (skip_pixels),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  lsbx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  lsbx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (pop),
    .decrypt_enable (decrypt_enable),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_value     (char_value),
    .end_found      (end_found)
  );

endmodule

/* rtl/core/lsbx_front.sv */
// lsbx_front: pixel intake, frame skip and 2-bit pair packing
// depends on lsbx_pkg
`timescale 1ns / 1ps

module lsbx_front import lsbx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_start,
  input  logic [15:0] skip_pixels,
  input  logic        queue_full,
  output logic        push,
  output lsbx_item_t  push_item
);

  logic [5:0]  bit_accumulator;
  logic [1:0]  pair_count;
  logic [15:0] skip_counter;
  logic        message_done;

  logic [5:0]  bit_accumulator_next;
  logic [1:0]  pair_count_next;
  logic [15:0] skip_counter_next;
  logic        message_done_next;
  logic        produced;
  logic        in_fire;

  assign in_ready = !queue_full;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && produced;

  always_comb begin
    logic [1:0] pairs [3];
    logic       stop;
    pairs[0] = red[1:0];
    pairs[1] = green[1:0];
    pairs[2] = blue[1:0];
    stop = 1'b0;
    produced = 1'b0;
    push_item = '0;
    bit_accumulator_next = bit_accumulator;
    pair_count_next = pair_count;
    skip_counter_next = skip_counter;
    message_done_next = message_done;
    if (frame_start) begin
      bit_accumulator_next = '0;
      pair_count_next = '0;
      skip_counter_next = '0;
      message_done_next = 1'b0;
    end
    if (!message_done_next) begin
      if (skip_counter_next < skip_pixels) begin
        skip_counter_next = skip_counter_next + 16'd1;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (!stop) begin
            if (pair_count_next == 2'd3) begin
              push_item.raw = {bit_accumulator_next, pairs[k]};
              produced = 1'b1;
              bit_accumulator_next = '0;
              pair_count_next = '0;
              if (push_item.raw == TERMINATOR) begin
                push_item.is_end = 1'b1;
                message_done_next = 1'b1;
                stop = 1'b1;
              end
            end else begin
              bit_accumulator_next = {bit_accumulator_next[3:0], pairs[k]};
              pair_count_next = pair_count_next + 2'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      pair_count <= '0;
      skip_counter <= '0;
      message_done <= 1'b0;
    end else if (in_fire) begin
      bit_accumulator <= bit_accumulator_next;
      pair_count <= pair_count_next;
      skip_counter <= skip_counter_next;
      message_done <= message_done_next;
    end
  end

endmodule

/* rtl/core/lsbx_queue.sv */
// lsbx_queue: short fifo between front end and output stage
// depends on lsbx_pkg
`timescale 1ns / 1ps

module lsbx_queue import lsbx_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lsbx_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output lsbx_item_t head_item
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lsbx_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/lsbx_back.sv */
// lsbx_back: end marker formatting, optional decrypt and output register
// depends on lsbx_pkg
`timescale 1ns / 1ps

module lsbx_back import lsbx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  lsbx_item_t head_item,
  output logic       pop,
  input  logic       decrypt_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] char_value,
  output logic       end_found
);

  function automatic logic [7:0] shift_down(input logic [7:0] b);
    logic [7:0] r;
    if (b == CH_LOWER_A) begin
      r = CH_LOWER_Z;
    end else if (b == CH_UPPER_A) begin
      r = CH_UPPER_Z;
    end else if (b == CH_SPACE) begin
      r = b;
    end else begin
      r = b - 8'd1;
    end
    return r;
  endfunction

  logic [7:0] char_value_next;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    if (head_item.is_end) begin
      char_value_next = '0;
    end else if (decrypt_enable) begin
      char_value_next = shift_down(head_item.raw);
    end else begin
      char_value_next = head_item.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_value <= char_value_next;
      end_found <= head_item.is_end;
    end
  end

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for lsb_stego_byte_extractor_unit
// depends on lsbx_pkg and the extractor rtl; predicts every transfer and checks it
`timescale 1ns / 1ps

module tb;
  import lsbx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_PIXELS = 140;
  localparam int unsigned RAND_PHASES  = 6;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            red = '0;
  logic [7:0]            green = '0;
  logic [7:0]            blue = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            char_value;
  logic                  end_found;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SKIP_PIXELS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state and its copy of the registers
  logic [15:0] skip_pixels_q;
  logic        decrypt_q;
  logic [5:0]  pair_acc;
  logic [1:0]  pairs_held;
  logic [15:0] pixels_skipped;
  logic        msg_done;

  char_result_t expected_chars[$];
  logic [7:0]   message_bytes[$];

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned live_pixels;
  int unsigned chars_seen;
  int unsigned ends_seen;
  int unsigned settings_used;
  logic        in_quiet;

  lsb_stego_byte_extractor_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_value (char_value),
    .end_found  (end_found),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] decrypt_char(input logic [7:0] c);
    if (c == CH_LOWER_A) return CH_LOWER_Z;
    if (c == CH_UPPER_A) return CH_UPPER_Z;
    if (c == CH_SPACE) return c;
    return c - 8'd1;
  endfunction

  function automatic void clear_frame_state();
    pair_acc       = '0;
    pairs_held     = '0;
    pixels_skipped = '0;
    msg_done       = 1'b0;
  endfunction

  // packs the low pairs of one accepted pixel and queues any finished byte
  function automatic void predict_chars(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic fs);
    logic [1:0]   pr [3];
    logic [7:0]   rebuilt;
    char_result_t res;
    pr[0] = r[1:0];
    pr[1] = g[1:0];
    pr[2] = b[1:0];
    if (fs) clear_frame_state();
    if (msg_done) return;
    live_pixels++;
    if (pixels_skipped < skip_pixels_q) begin
      pixels_skipped++;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      if (pairs_held == 2'd3) begin
        rebuilt    = {pair_acc, pr[k]};
        pair_acc   = '0;
        pairs_held = '0;
        if (rebuilt == TERMINATOR) begin
          msg_done = 1'b1;
          res.ch   = '0;
          res.fin  = 1'b1;
          expected_chars.push_back(res);
          return;
        end
        res.ch  = decrypt_q ? decrypt_char(rebuilt) : rebuilt;
        res.fin = 1'b0;
        expected_chars.push_back(res);
      end else begin
        pair_acc   = {pair_acc[3:0], pr[k]};
        pairs_held = pairs_held + 2'd1;
      end
    end
  endfunction

  function automatic logic [7:0] rand_chan(input logic [1:0] p);
    logic [31:0] rv;
    rv = $urandom;
    return {rv[7:2], p};
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic fs);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    red         <= r;
    green       <= g;
    blue        <= b;
    frame_start <= fs;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    predict_chars(r, g, b, fs);
  endtask

  // skip pixels, then message_bytes as pairs, extra loose pairs, then tail pixels
  task automatic send_frame(input int extra_pairs, input int tail_pixels);
    logic [1:0] pairs[$];
    logic [31:0] rv;
    logic first;
    first = 1'b1;
    in_quiet = ($urandom_range(0, 3) == 0);
    repeat (skip_pixels_q) begin
      send_pixel(rand_byte(), rand_byte(), rand_byte(), first);
      first = 1'b0;
    end
    foreach (message_bytes[i]) begin
      pairs.push_back(message_bytes[i][7:6]);
      pairs.push_back(message_bytes[i][5:4]);
      pairs.push_back(message_bytes[i][3:2]);
      pairs.push_back(message_bytes[i][1:0]);
    end
    repeat (extra_pairs) begin
      rv = $urandom;
      pairs.push_back(rv[1:0]);
    end
    while (pairs.size() % 3 != 0) begin
      rv = $urandom;
      pairs.push_back(rv[1:0]);
    end
    for (int i = 0; i < pairs.size(); i += 3) begin
      send_pixel(rand_chan(pairs[i]), rand_chan(pairs[i+1]), rand_chan(pairs[i+2]), first);
      first = 1'b0;
    end
    repeat (tail_pixels) begin
      send_pixel(rand_byte(), rand_byte(), rand_byte(), first);
      first = 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_SKIP_PIXELS) skip_pixels_q = val;
    else decrypt_q = val[0];
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ready side: a fresh stall before each transfer, with quiet stretches
  initial begin
    int stall;
    int run;
    logic quiet;
    run   = 0;
    quiet = 1'b0;
    @(negedge clk);
    forever begin
      if (run == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        run   = $urandom_range(10, 40);
      end
      run--;
      stall = quiet ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    char_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer char %02h end %0b",
                                  char_value, end_found));
      end else begin
        want = expected_chars.pop_front();
        if (char_value !== want.ch)
          report_mismatch($sformatf("char_value %02h, want %02h", char_value, want.ch));
        if (end_found !== want.fin)
          report_mismatch($sformatf("end_found %0b, want %0b", end_found, want.fin));
        if (want.fin) ends_seen++;
        else chars_seen++;
      end
    end
  end

  task automatic test_channel_extremes();
    write_reg(CFG_SKIP_PIXELS, 16'd0);
    write_reg(CFG_DECRYPT, 16'd0);
    in_quiet = 1'b0;
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    wait_idle();
  endtask

  // decrypt cases, zero byte wrap, then a terminator ending mid pixel
  task automatic test_decrypt_and_terminator();
    write_reg(CFG_DECRYPT, 16'd1);
    message_bytes = {CH_LOWER_A, CH_UPPER_A, CH_SPACE, 8'h00, TERMINATOR, 8'h51};
    send_frame(0, 1);
    wait_idle();
  endtask

  task automatic test_partial_byte_discard();
    message_bytes = {8'h4B};
    send_frame(2, 0);
    send_pixel(8'hAA, 8'h55, 8'h03, 1'b1);
    send_pixel(8'h02, 8'hFD, 8'h00, 1'b0);
    wait_idle();
  endtask

  task automatic test_skip_window();
    write_reg(CFG_SKIP_PIXELS, 16'hFFFF);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    wait_idle();
    write_reg(CFG_SKIP_PIXELS, 16'd2);
    write_reg(CFG_DECRYPT, 16'd0);
    send_pixel(8'h13, 8'h26, 8'h39, 1'b1);
    send_pixel(8'h4C, 8'h5F, 8'h72, 1'b0);
    send_pixel(8'h85, 8'h98, 8'hAB, 1'b0);
    send_pixel(8'hBE, 8'hD1, 8'hE4, 1'b0);
    wait_idle();
    // counter sits above the new, lower window
    write_reg(CFG_SKIP_PIXELS, 16'd1);
    send_pixel(8'hF7, 8'h0A, 8'h1D, 1'b0);
    wait_idle();
    // raised window resumes skipping mid frame
    write_reg(CFG_SKIP_PIXELS, 16'd4);
    send_pixel(8'h30, 8'h43, 8'h56, 1'b0);
    send_pixel(8'h69, 8'h7C, 8'h8F, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int kind;
    int len;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: write_reg(CFG_SKIP_PIXELS, 16'd0);
        1: write_reg(CFG_SKIP_PIXELS, 16'd1);
        default: write_reg(CFG_SKIP_PIXELS, 16'($urandom_range(0, 6)));
      endcase
      write_reg(CFG_DECRYPT, 16'(ph % 2));
      start = live_pixels;
      while (live_pixels - start < PHASE_PIXELS) begin
        kind = $urandom_range(0, 19);
        message_bytes = {};
        len = $urandom_range(1, 20);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0: message_bytes.push_back(CH_LOWER_A);
            1: message_bytes.push_back(CH_UPPER_A);
            2: message_bytes.push_back(CH_SPACE);
            3: message_bytes.push_back(8'h00);
            4: message_bytes.push_back(8'hFF);
            default: message_bytes.push_back(rand_byte());
          endcase
        end
        if (kind < 14) begin
          message_bytes.push_back(TERMINATOR);
          send_frame($urandom_range(0, 2), $urandom_range(0, 3));
        end else if (kind < 17) begin
          // broken frame: no terminator added, extra pairs may leave it mid byte
          send_frame($urandom_range(1, 3), 0);
        end else begin
          in_quiet = 1'b0;
          repeat ($urandom_range(1, 6))
            send_pixel(rand_byte(), rand_byte(), rand_byte(),
                       1'($urandom_range(0, 1)));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    cycles        = 0;
    mismatches    = 0;
    pixels_sent   = 0;
    live_pixels   = 0;
    chars_seen    = 0;
    ends_seen     = 0;
    settings_used = 0;
    in_quiet      = 1'b0;
    skip_pixels_q = '0;
    decrypt_q     = 1'b0;
    clear_frame_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_channel_extremes();
    test_decrypt_and_terminator();
    test_partial_byte_discard();
    test_skip_window();
    test_random_frames();

    wait_idle();
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_chars.size()));
    $display("%0d pixels sent (%0d not ignored), %0d register writes",
             pixels_sent, live_pixels, settings_used);
    $display("%0d characters and %0d end markers compared, %0d mismatches",
             chars_seen, ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* lsb_stego_byte_extractor_unit.f */
rtl/core/lsbx_pkg.sv
rtl/core/lsbx_front.sv
rtl/core/lsbx_queue.sv
rtl/core/lsbx_back.sv
rtl/core/lsb_stego_byte_extractor_unit.sv
tb/tb.sv
